### rtl/trial_division_factoriser_macros.svh
// Assertion macros for the trial division factoriser.
// Included by the top level; depends on nothing else.
`ifndef TRIAL_DIVISION_FACTORISER_MACROS_SVH
`define TRIAL_DIVISION_FACTORISER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/tdf_pkg.sv
// Shared types and constants of the trial division factoriser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tdf_pkg;

  localparam int NUMBER_W = 64;
  localparam int CFG_W    = 13;
  localparam int KIND_W   = 2;

  localparam logic [CFG_W-1:0] PRIMES_IN_USE_RESET = 13'd6542;

  // 6542 primes all lie below 2^16, so the sieve never needs more range.
  localparam int SIEVE_W_MAX = 16;

  // Divider retires this many quotient bits per cycle.
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = NUMBER_W / DIV_BITS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef enum logic [KIND_W-1:0] {
    KIND_TABLE      = 2'd0,
    KIND_FINAL      = 2'd1,
    KIND_UNFACTORED = 2'd2,
    KIND_ZERO       = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_TABLE,
    EMIT_COFACTOR,
    EMIT_REMAINDER,
    EMIT_ZERO
  } emit_sel_t;

  typedef enum logic [3:0] {
    CS_BOOT,
    CS_IDLE,
    CS_START,
    CS_FETCH,
    CS_SQUARE,
    CS_CHECK,
    CS_DIV_START,
    CS_DIVIDE,
    CS_RESULT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    SV_CLEAR,
    SV_SQUARE,
    SV_TEST,
    SV_MARK,
    SV_SCAN_RD,
    SV_SCAN_CHK,
    SV_READY
  } sieve_state_t;

  typedef struct packed {
    logic      load;
    logic      latch_prime;
    logic      div_start;
    logic      div_step;
    logic      take_quot;
    logic      next_prime;
    emit_sel_t emit_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic num_zero;
    logic limit_zero;
    logic square_above;
    logic rem_zero;
    logic quot_one;
    logic last_prime;
    logic div_last;
  } dp_status_t;

endpackage

### rtl/tdf_prime_store.sv
// Prime table: builds the ascending primes with a sieve after reset, then serves reads.
// Depends on tdf_pkg.
`timescale 1ns / 1ps

module tdf_prime_store #(
  parameter int PRIME_COUNT = 6542,
  parameter int PRIME_W     = 16,
  localparam int ADDR_W     = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [PRIME_W-1:0]         rd_data,
  output logic                       ready,
  output logic [tdf_pkg::CFG_W-1:0]  loaded_count
);

  import tdf_pkg::*;

  localparam int SIEVE_N = 1 << PRIME_W;
  localparam int CNT_W   = $clog2(PRIME_COUNT + 1);

  sieve_state_t        state_r, state_nxt;
  logic [PRIME_W-1:0]  addr_r;
  logic [PRIME_W-1:0]  p_r;
  logic [CNT_W-1:0]    count_r;
  logic [2*PRIME_W-1:0] sq_r;
  logic [PRIME_W:0]    m_r;

  logic                mark_mem [SIEVE_N];
  logic                mark_q;
  logic [PRIME_W-1:0]  prime_mem [PRIME_COUNT];
  logic [PRIME_W-1:0]  rd_q;

  logic                mark_we;
  logic                mark_wbit;
  logic [PRIME_W-1:0]  mark_waddr;
  logic [PRIME_W-1:0]  mark_raddr;
  logic                prime_we;
  logic                sq_out_of_range;
  logic                count_full;

  assign sq_out_of_range = |sq_r[2*PRIME_W-1:PRIME_W];
  assign count_full      = (count_r == CNT_W'(PRIME_COUNT - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SV_CLEAR: begin
        if (&addr_r) state_nxt = SV_SQUARE;
      end
      SV_SQUARE: state_nxt = SV_TEST;
      SV_TEST: begin
        if (sq_out_of_range) state_nxt = SV_SCAN_RD;
        else if (mark_q)     state_nxt = SV_SQUARE;
        else                 state_nxt = SV_MARK;
      end
      SV_MARK: begin
        if (m_r[PRIME_W]) state_nxt = SV_SQUARE;
      end
      SV_SCAN_RD: state_nxt = SV_SCAN_CHK;
      SV_SCAN_CHK: begin
        if ((!mark_q && count_full) || (&addr_r)) state_nxt = SV_READY;
        else                                      state_nxt = SV_SCAN_RD;
      end
      SV_READY: state_nxt = SV_READY;
      default:  state_nxt = SV_CLEAR;
    endcase
  end

  always_comb begin
    mark_we    = 1'b0;
    mark_wbit  = 1'b0;
    mark_waddr = addr_r;
    mark_raddr = addr_r;
    prime_we   = 1'b0;
    unique case (state_r)
      SV_CLEAR:  mark_we = 1'b1;
      SV_SQUARE: mark_raddr = p_r;
      SV_MARK: begin
        mark_we    = !m_r[PRIME_W];
        mark_wbit  = 1'b1;
        mark_waddr = m_r[PRIME_W-1:0];
      end
      SV_SCAN_CHK: prime_we = !mark_q;
      SV_TEST, SV_SCAN_RD, SV_READY: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SV_CLEAR;
      addr_r  <= '0;
      p_r     <= PRIME_W'(2);
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        SV_CLEAR: begin
          addr_r <= (&addr_r) ? '0 : addr_r + 1'b1;
        end
        SV_TEST: begin
          if (sq_out_of_range) addr_r <= PRIME_W'(2);
          else if (mark_q)     p_r <= p_r + 1'b1;
        end
        SV_MARK: begin
          if (m_r[PRIME_W]) p_r <= p_r + 1'b1;
        end
        SV_SCAN_CHK: begin
          if (!mark_q) count_r <= count_r + 1'b1;
          addr_r <= addr_r + 1'b1;
        end
        SV_SQUARE, SV_SCAN_RD, SV_READY: ;
        default: ;
      endcase
    end
  end

  // Square of the sieving prime and the running multiple
  always_ff @(posedge clk) begin
    if (state_r == SV_SQUARE) begin
      sq_r <= {{PRIME_W{1'b0}}, p_r} * {{PRIME_W{1'b0}}, p_r};
    end
    if (state_r == SV_TEST) begin
      m_r <= sq_r[PRIME_W:0];
    end else if (state_r == SV_MARK) begin
      m_r <= m_r + {1'b0, p_r};
    end
  end

  // Composite marks
  always_ff @(posedge clk) begin
    if (mark_we) mark_mem[mark_waddr] <= mark_wbit;
    mark_q <= mark_mem[mark_raddr];
  end

  // Compacted prime list
  always_ff @(posedge clk) begin
    if (prime_we) prime_mem[count_r[ADDR_W-1:0]] <= addr_r;
    rd_q <= prime_mem[rd_addr];
  end

  assign rd_data      = rd_q;
  assign ready        = (state_r == SV_READY);
  assign loaded_count = CFG_W'(count_r);

endmodule

### rtl/tdf_datapath.sv
// Datapath: cofactor, current prime and its square, radix-16 restoring divider, result registers.
// Depends on tdf_pkg; driven by tdf_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module tdf_datapath #(
  parameter int PRIME_COUNT = 6542,
  parameter int PRIME_W     = 16,
  localparam int ADDR_W     = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdf_pkg::dp_cmd_t              cmd,
  output tdf_pkg::dp_status_t           status,
  input  logic [tdf_pkg::NUMBER_W-1:0]  in_number,
  input  logic                          cfg_we,
  input  logic [tdf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic [tdf_pkg::CFG_W-1:0]     loaded_count,
  output logic [ADDR_W-1:0]             tbl_addr,
  input  logic [PRIME_W-1:0]            tbl_data,
  output logic                          out_valid,
  output logic [tdf_pkg::NUMBER_W-1:0]  out_factor,
  output logic [tdf_pkg::KIND_W-1:0]    out_factor_kind,
  output logic                          out_last
);

  import tdf_pkg::*;

  logic [CFG_W-1:0]     primes_in_use_r;
  logic [NUMBER_W-1:0]  v_r;
  logic [CFG_W-1:0]     limit_r;
  logic [ADDR_W-1:0]    idx_r;
  logic [PRIME_W-1:0]   p_r;
  logic [2*PRIME_W-1:0] sq_r;
  logic [NUMBER_W-1:0]  dnd_r, dnd_nxt;
  logic [PRIME_W-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [PRIME_W:0]     trial;

  logic                 out_valid_r;
  logic [NUMBER_W-1:0]  out_factor_r;
  kind_t                out_kind_r;
  logic                 out_last_r;

  // Restoring division, DIV_BITS quotient bits per cycle; quotient fills dnd from the bottom
  always_comb begin
    rem_nxt = rem_r;
    dnd_nxt = dnd_r;
    trial   = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial   = {rem_nxt, dnd_nxt[NUMBER_W-1]};
      dnd_nxt = {dnd_nxt[NUMBER_W-2:0], 1'b0};
      if (trial >= {1'b0, p_r}) begin
        rem_nxt    = PRIME_W'(trial - {1'b0, p_r});
        dnd_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[PRIME_W-1:0];
      end
    end
  end

  assign status.num_zero     = (v_r == '0);
  assign status.limit_zero   = (limit_r == '0);
  assign status.square_above = (NUMBER_W'(sq_r) > v_r);
  assign status.rem_zero     = (rem_r == '0);
  assign status.quot_one     = (dnd_r == NUMBER_W'(1));
  assign status.last_prime   = ((CFG_W'(idx_r) + CFG_W'(1)) == limit_r);
  assign status.div_last     = (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1));

  assign tbl_addr = idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primes_in_use_r <= PRIMES_IN_USE_RESET;
      out_valid_r     <= 1'b0;
      cnt_r           <= '0;
    end else begin
      if (cfg_we) primes_in_use_r <= cfg_wdata;
      out_valid_r <= (cmd.emit_sel != EMIT_NONE);
      if (cmd.div_start)     cnt_r <= '0;
      else if (cmd.div_step) cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v_r     <= in_number;
      idx_r   <= '0;
      limit_r <= (primes_in_use_r > loaded_count) ? loaded_count : primes_in_use_r;
    end else begin
      if (cmd.take_quot)  v_r   <= dnd_r;
      if (cmd.next_prime) idx_r <= idx_r + 1'b1;
    end
    if (cmd.latch_prime) begin
      p_r  <= tbl_data;
      sq_r <= {{PRIME_W{1'b0}}, tbl_data} * {{PRIME_W{1'b0}}, tbl_data};
    end
    if (cmd.div_start) begin
      dnd_r <= v_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dnd_r <= dnd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.emit_sel)
      EMIT_TABLE: begin
        out_factor_r <= NUMBER_W'(p_r);
        out_kind_r   <= KIND_TABLE;
        out_last_r   <= status.quot_one;
      end
      EMIT_COFACTOR: begin
        out_factor_r <= v_r;
        out_kind_r   <= KIND_FINAL;
        out_last_r   <= 1'b1;
      end
      EMIT_REMAINDER: begin
        out_factor_r <= v_r;
        out_kind_r   <= (v_r == NUMBER_W'(1)) ? KIND_FINAL : KIND_UNFACTORED;
        out_last_r   <= 1'b1;
      end
      EMIT_ZERO: begin
        out_factor_r <= '0;
        out_kind_r   <= KIND_ZERO;
        out_last_r   <= 1'b1;
      end
      EMIT_NONE: ;
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_factor      = out_factor_r;
  assign out_factor_kind = out_kind_r;
  assign out_last        = out_last_r;

endmodule

### rtl/tdf_ctrl.sv
// Controller state machine: sequences table fetch, square check and divisions per request.
// Depends on tdf_pkg; drives tdf_datapath through dp_cmd_t.
`timescale 1ns / 1ps

module tdf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 table_ready,
  input  tdf_pkg::dp_status_t  status,
  output tdf_pkg::dp_cmd_t     cmd
);

  import tdf_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= CS_BOOT;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CS_BOOT: begin
        if (table_ready) state_nxt = CS_IDLE;
      end
      CS_IDLE: begin
        if (start) state_nxt = CS_START;
      end
      CS_START: begin
        if (status.num_zero || status.limit_zero) state_nxt = CS_IDLE;
        else                                      state_nxt = CS_FETCH;
      end
      CS_FETCH:  state_nxt = CS_SQUARE;
      CS_SQUARE: state_nxt = CS_CHECK;
      CS_CHECK: begin
        if (status.square_above) state_nxt = CS_IDLE;
        else                     state_nxt = CS_DIV_START;
      end
      CS_DIV_START: state_nxt = CS_DIVIDE;
      CS_DIVIDE: begin
        if (status.div_last) state_nxt = CS_RESULT;
      end
      CS_RESULT: begin
        if (status.rem_zero) begin
          state_nxt = status.quot_one ? CS_IDLE : CS_DIV_START;
        end else begin
          state_nxt = status.last_prime ? CS_IDLE : CS_FETCH;
        end
      end
      default: state_nxt = CS_BOOT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.emit_sel = EMIT_NONE;
    busy         = 1'b1;
    unique case (state_r)
      CS_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      CS_START: begin
        if (status.num_zero)        cmd.emit_sel = EMIT_ZERO;
        else if (status.limit_zero) cmd.emit_sel = EMIT_REMAINDER;
      end
      CS_SQUARE: cmd.latch_prime = 1'b1;
      CS_CHECK: begin
        if (status.square_above) cmd.emit_sel = EMIT_COFACTOR;
      end
      CS_DIV_START: cmd.div_start = 1'b1;
      CS_DIVIDE:    cmd.div_step  = 1'b1;
      CS_RESULT: begin
        if (status.rem_zero) begin
          cmd.emit_sel  = EMIT_TABLE;
          cmd.take_quot = 1'b1;
        end else if (status.last_prime) begin
          cmd.emit_sel = EMIT_REMAINDER;
        end else begin
          cmd.next_prime = 1'b1;
        end
      end
      CS_BOOT, CS_FETCH: ;
      default: ;
    endcase
  end

endmodule

### rtl/trial_division_factoriser.sv
// Top level of the trial division factoriser: prime table, controller and datapath.
// Depends on tdf_pkg, tdf_prime_store, tdf_ctrl, tdf_datapath and the assertion macro header.
`timescale 1ns / 1ps

`include "trial_division_factoriser_macros.svh"

// Factors one unsigned 64-bit number per request by trial division against the
// ascending primes below 2^min(PRIME_WIDTH,16) (at most PRIME_COUNT). A request
// is taken on a rising edge with start high and busy low; results then appear
// one per out_valid strobe, each valid for exactly one cycle, and the receiver
// cannot hold them off. The strobe marked out_last closes the request.
// After reset the block builds its prime table with a sieve and holds busy
// high meanwhile: it clears the sieve, strikes the composites and then
// compacts the primes into the table.
// Per request the block first rejects a zero number, then for each prime tried
// it fetches the prime, squares it and compares the square with the cofactor,
// and divides while the square does not exceed it, dividing again by the same
// prime after every exact division. The 64-bit by prime division is the
// pacing unit: it retires 4 quotient bits per cycle. A worst-case request
// walks all 6542 primes at the defaults. cfg_wdata sets how many table primes are tried
// (saturated to the number actually loaded); write it only while idle.
module trial_division_factoriser #(
  parameter int PRIME_COUNT = 6542,
  parameter int PRIME_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [tdf_pkg::NUMBER_W-1:0]  in_number,
  input  logic                          cfg_we,
  input  logic [tdf_pkg::CFG_W-1:0]     cfg_wdata,
  output logic                          out_valid,
  output logic [tdf_pkg::NUMBER_W-1:0]  out_factor,
  output logic [tdf_pkg::KIND_W-1:0]    out_factor_kind,
  output logic                          out_last
);

  import tdf_pkg::*;

  // Primes above 2^16 are never needed for 6542 entries, so cap the sieve range.
  localparam int PRIME_W = (PRIME_WIDTH < SIEVE_W_MAX) ? PRIME_WIDTH : SIEVE_W_MAX;
  localparam int ADDR_W  = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;

  dp_cmd_t             cmd;
  dp_status_t          status;
  logic                table_ready;
  logic [CFG_W-1:0]    loaded_count;
  logic [ADDR_W-1:0]   tbl_addr;
  logic [PRIME_W-1:0]  tbl_data;

  // Sieve-built prime list; read port is registered
  tdf_prime_store #(
    .PRIME_COUNT (PRIME_COUNT),
    .PRIME_W     (PRIME_W)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .rd_addr      (tbl_addr),
    .rd_data      (tbl_data),
    .ready        (table_ready),
    .loaded_count (loaded_count)
  );

  // Sequencer: one request at a time, one prime at a time
  tdf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .table_ready (table_ready),
    .status      (status),
    .cmd         (cmd)
  );

  // Cofactor, prime square compare, divider and result registers
  tdf_datapath #(
    .PRIME_COUNT (PRIME_COUNT),
    .PRIME_W     (PRIME_W)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_number       (in_number),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .loaded_count    (loaded_count),
    .tbl_addr        (tbl_addr),
    .tbl_data        (tbl_data),
    .out_valid       (out_valid),
    .out_factor      (out_factor),
    .out_factor_kind (out_factor_kind),
    .out_last        (out_last)
  );

  // A result only ever follows a cycle of work on a request.
  `TDF_ASSERT_IMP(a_result_after_work, clk, rst_n, out_valid, $past(busy))
  // An accepted request moves the block into work on the next cycle.
  `TDF_ASSERT_NXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy)
  // A rejected zero is a lone result carrying zero.
  `TDF_ASSERT_IMP(a_zero_alone, clk, rst_n, out_valid && (out_factor_kind == KIND_ZERO),
                  out_last && (out_factor == '0))
  // Only table primes can be followed by further results.
  `TDF_ASSERT_IMP(a_more_only_table, clk, rst_n, out_valid && !out_last, out_factor_kind == KIND_TABLE)

endmodule
